// ===== hw/rtl/bcmp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcmp_pkg
// Shared types and constants for the binomial coefficient mod prime block.
// ----------------------------------------------------------------------------
package bcmp_pkg;

    localparam int TABLE_SIZE = 1024;
    localparam int AW = $clog2(TABLE_SIZE);
    localparam int MW = 31;
    localparam logic [MW-1:0] MOD_RESET = 31'd1000000007;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_BUILT = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;

    localparam logic REQ_REBUILD = 1'b0;
    localparam logic REQ_QUERY   = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [9:0] n;
        logic [9:0] r;
    } req_t;

    typedef struct packed {
        logic [MW-1:0] value;
        logic [1:0]    status;
    } rsp_t;

    // multiplier operand selects
    localparam logic [2:0] OP_A_ACC  = 3'd0;
    localparam logic [2:0] OP_A_IDX  = 3'd1;
    localparam logic [2:0] OP_A_BASE = 3'd2;
    localparam logic [2:0] OP_A_FACT = 3'd3;
    localparam logic [2:0] OP_A_ONE  = 3'd4;
    localparam logic [2:0] OP_A_NEXT = 3'd5;

    localparam logic [1:0] OP_B_ACC  = 2'd0;
    localparam logic [1:0] OP_B_BASE = 2'd1;
    localparam logic [1:0] OP_B_RD   = 2'd2;
    localparam logic [1:0] OP_B_ONE  = 2'd3;

    // datapath commands
    typedef struct packed {
        logic          mul_start;
        logic [2:0]    sel_a;
        logic [1:0]    sel_b;
        logic          acc_load;   // acc <= product
        logic          base_load;  // base <= product
        logic          acc_one;    // acc <= 1 mod m
        logic          exp_load;   // exponent <= m-2
        logic          exp_shift;
        logic          idx_load;
        logic [AW:0]   idx_value;
        logic          idx_inc;
        logic          idx_dec;
        logic          fact_we;
        logic          ifact_we;
        logic          rd_fact;    // read fact[n]
        logic [1:0]    rd_ifact;   // 1: ifact[r], 2: ifact[n-r]
        logic          rd_latch;
        logic          save_fact;
    } cmd_t;

    typedef struct packed {
        logic        mul_done;
        logic        exp_zero;
        logic        exp_lsb;
        logic [AW:0] idx;
    } sts_t;

    localparam logic [1:0] RD_NONE = 2'd0;
    localparam logic [1:0] RD_R    = 2'd1;
    localparam logic [1:0] RD_NR   = 2'd2;

endpackage

// ===== hw/rtl/bcmp_modmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcmp_modmul
// Serial modular multiplier, radix 2 shift-and-add, one bit per cycle.
// ----------------------------------------------------------------------------
module bcmp_modmul
    import bcmp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [MW-1:0] a,
    input  logic [MW-1:0] b,
    input  logic [MW-1:0] modulus,
    output logic          done,
    output logic [MW-1:0] product
);

    logic          busy_reg, busy_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [MW-1:0] acc_reg, acc_next;
    logic [MW-1:0] a_reg, a_next;
    logic [MW-1:0] b_reg, b_next;
    logic          done_reg, done_next;
    logic [MW:0]   dbl, dbl_red, add, add_red;

    // one step: acc = 2*acc mod m, then + b if bit set
    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
        add     = dbl_red + {1'b0, b_reg};
        add_red = (add >= {1'b0, modulus}) ? add - {1'b0, modulus} : add;
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd30;
            acc_next  = '0;
            a_next    = a;
            // b is always already reduced below m; a need not be
            b_next    = (modulus < 31'd2) ? '0 : b;
        end
        else if (busy_reg)
        begin
            acc_next = a_reg[MW-1] ? add_red[MW-1:0] : dbl_red[MW-1:0];
            a_next   = {a_reg[MW-2:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== hw/rtl/bcmp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcmp_datapath
// Tables, exponent register, index counter and the shared modular multiplier.
// ----------------------------------------------------------------------------
module bcmp_datapath
    import bcmp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cmd_t          cmd,
    input  logic [MW-1:0] modulus,
    input  logic [9:0]    arg_n,
    input  logic [9:0]    arg_r,
    output sts_t          sts,
    output logic [MW-1:0] acc
);

    logic [MW-1:0] fact_mem  [TABLE_SIZE];
    logic [MW-1:0] ifact_mem [TABLE_SIZE];

    logic [MW-1:0] acc_reg, base_reg, rd_reg, fact_rd_reg, ifact_rd_reg;
    logic [MW-1:0] exp_reg;
    logic [AW:0]   idx_reg;
    logic [MW-1:0] mul_a, mul_b, product, one_m, idx_m;
    logic          mul_done;
    logic [AW-1:0] nr_addr;

    assign one_m   = (modulus < 31'd2) ? '0 : 31'd1;
    // index fits below m unless m is tiny; reduce by a compare chain is not
    // needed: the multiplier reduces a serially, so a raw index is fine
    assign idx_m   = {{(MW-AW-1){1'b0}}, idx_reg};
    assign nr_addr = arg_n - arg_r;

    // operand select
    always_comb
    begin
        unique case (cmd.sel_a)
            OP_A_ACC:  mul_a = acc_reg;
            OP_A_IDX:  mul_a = idx_m;
            OP_A_BASE: mul_a = base_reg;
            OP_A_FACT: mul_a = fact_rd_reg;
            OP_A_NEXT: mul_a = idx_m + 31'd1;
            default:   mul_a = one_m;
        endcase
        unique case (cmd.sel_b)
            OP_B_ACC:  mul_b = acc_reg;
            OP_B_BASE: mul_b = base_reg;
            OP_B_RD:   mul_b = rd_reg;
            default:   mul_b = one_m;
        endcase
    end

    bcmp_modmul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .modulus (modulus),
        .done    (mul_done),
        .product (product)
    );

    // table memories, one write and one read port each
    always_ff @(posedge clk)
    begin
        if (cmd.fact_we)
            fact_mem[idx_reg[AW-1:0]] <= acc_reg;
        if (cmd.ifact_we)
            ifact_mem[idx_reg[AW-1:0]] <= acc_reg;
        fact_rd_reg  <= fact_mem[arg_n];
        ifact_rd_reg <= ifact_mem[(cmd.rd_ifact == RD_NR) ? nr_addr : arg_r];
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.acc_one)
            acc_reg <= one_m;
        else if (cmd.acc_load)
            acc_reg <= product;
        if (cmd.base_load)
            base_reg <= product;
        else if (cmd.save_fact)
            base_reg <= acc_reg;
        if (cmd.rd_latch)
            rd_reg <= ifact_rd_reg;
        if (cmd.exp_load)
            exp_reg <= modulus - 31'd2;
        else if (cmd.exp_shift)
            exp_reg <= exp_reg >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (cmd.idx_load)
            idx_reg <= cmd.idx_value;
        else if (cmd.idx_inc)
            idx_reg <= idx_reg + 1'b1;
        else if (cmd.idx_dec)
            idx_reg <= idx_reg - 1'b1;
    end

    assign sts.mul_done = mul_done;
    assign sts.exp_zero = (exp_reg == '0);
    assign sts.exp_lsb  = exp_reg[0];
    assign sts.idx      = idx_reg;
    assign acc          = acc_reg;

endmodule

// ===== hw/rtl/bcmp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcmp_ctrl
// Sequencer for rebuild (factorials, exponentiation, inverse fill) and query.
// ----------------------------------------------------------------------------
module bcmp_ctrl
    import bcmp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  req_t          req,
    input  logic          cfg_we,
    input  logic [MW-1:0] modulus,
    input  sts_t          sts,
    input  logic [MW-1:0] acc,
    output cmd_t          cmd,
    output logic          busy,
    output logic          done,
    output rsp_t          rsp,
    output logic [9:0]    arg_n,
    output logic [9:0]    arg_r
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FWR    = 4'd1;  // write fact[idx]=acc
    localparam logic [3:0] S_FMUL   = 4'd2;  // acc *= idx
    localparam logic [3:0] S_PSTART = 4'd3;  // exponent loop head
    localparam logic [3:0] S_PMUL   = 4'd4;  // acc *= base
    localparam logic [3:0] S_PSQ    = 4'd5;  // base *= base
    localparam logic [3:0] S_IWR    = 4'd6;  // write ifact[idx]=acc
    localparam logic [3:0] S_IMUL   = 4'd7;  // acc *= idx
    localparam logic [3:0] S_QRD1   = 4'd8;
    localparam logic [3:0] S_QRD2   = 4'd9;
    localparam logic [3:0] S_QMUL1  = 4'd10;
    localparam logic [3:0] S_QMUL2  = 4'd11;
    localparam logic [3:0] S_QWAIT  = 4'd12;
    localparam logic [3:0] S_QSTART = 4'd13; // fact[n] * ifact[r]

    logic [3:0] state_reg, state_next;
    logic       ready_reg, ready_next;
    logic       wait_reg, wait_next;
    logic       done_reg, done_next;
    rsp_t       rsp_reg, rsp_next;
    logic [9:0] n_reg, n_next, r_reg, r_next;

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        wait_next  = 1'b0;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        n_next     = n_reg;
        r_next     = r_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next = req.n;
                    r_next = req.r;
                    rsp_next.value  = '0;
                    rsp_next.status = ST_OK;
                    if (req.req_type == REQ_REBUILD)
                    begin
                        cmd.acc_one   = 1'b1;
                        cmd.idx_load  = 1'b1;
                        cmd.idx_value = '0;
                        state_next    = S_FWR;
                    end
                    else if (!ready_reg)
                    begin
                        rsp_next.status = ST_NOT_BUILT;
                        done_next       = 1'b1;
                    end
                    else if (req.r > req.n)
                        done_next = 1'b1;
                    else
                        state_next = S_QRD1;
                end
            end
            S_FWR:
            begin
                cmd.fact_we = 1'b1;
                if (sts.idx == (AW+1)'(TABLE_SIZE - 1))
                begin
                    // start power: base = fact, acc = 1, exp = m-2
                    cmd.save_fact = 1'b1;
                    cmd.acc_one   = 1'b1;
                    cmd.exp_load  = 1'b1;
                    state_next    = S_PSTART;
                end
                else
                begin
                    // next factorial: (idx + 1) * fact[idx]
                    cmd.idx_inc   = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.sel_a     = OP_A_NEXT;
                    cmd.sel_b     = OP_B_ACC;
                    wait_next     = 1'b1;
                    state_next    = S_FMUL;
                end
            end
            S_FMUL:
            begin
                cmd.sel_a = OP_A_IDX;
                if (sts.mul_done && !wait_reg)
                begin
                    cmd.acc_load = 1'b1;
                    state_next   = S_FWR;
                end
            end
            S_PSTART:
            begin
                if (modulus < 31'd2 || sts.exp_zero)
                begin
                    if (modulus < 31'd2)
                        cmd.acc_one = 1'b1; // one_m is zero here
                    state_next = S_IWR;
                end
                else if (sts.exp_lsb)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.sel_a     = OP_A_ACC;
                    cmd.sel_b     = OP_B_BASE;
                    wait_next     = 1'b1;
                    state_next    = S_PMUL;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.sel_a     = OP_A_BASE;
                    cmd.sel_b     = OP_B_BASE;
                    wait_next     = 1'b1;
                    state_next    = S_PSQ;
                end
            end
            S_PMUL:
            begin
                if (sts.mul_done && !wait_reg)
                begin
                    cmd.acc_load  = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.sel_a     = OP_A_BASE;
                    cmd.sel_b     = OP_B_BASE;
                    wait_next     = 1'b1;
                    state_next    = S_PSQ;
                end
            end
            S_PSQ:
            begin
                if (sts.mul_done && !wait_reg)
                begin
                    cmd.base_load = 1'b1;
                    cmd.exp_shift = 1'b1;
                    state_next    = S_PSTART;
                end
            end
            S_IWR:
            begin
                cmd.ifact_we = 1'b1;
                if (sts.idx == '0)
                begin
                    ready_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.sel_a     = OP_A_IDX;
                    cmd.sel_b     = OP_B_ACC;
                    wait_next     = 1'b1;
                    state_next    = S_IMUL;
                end
            end
            S_IMUL:
            begin
                if (sts.mul_done && !wait_reg)
                begin
                    cmd.acc_load = 1'b1;
                    cmd.idx_dec  = 1'b1;
                    state_next   = S_IWR;
                end
            end
            S_QRD1:
            begin
                // fact[n] and ifact[r] read this cycle
                cmd.rd_ifact = RD_R;
                state_next   = S_QRD2;
            end
            S_QRD2:
            begin
                // hold ifact[r], start reading ifact[n-r]
                cmd.rd_ifact  = RD_NR;
                cmd.rd_latch  = 1'b1;
                state_next    = S_QSTART;
            end
            S_QSTART:
            begin
                cmd.rd_ifact  = RD_NR;
                cmd.mul_start = 1'b1;
                cmd.sel_a     = OP_A_FACT;
                cmd.sel_b     = OP_B_RD;
                wait_next     = 1'b1;
                state_next    = S_QMUL1;
            end
            S_QMUL1:
            begin
                cmd.rd_ifact = RD_NR;
                if (sts.mul_done && !wait_reg)
                begin
                    cmd.acc_load = 1'b1;
                    cmd.rd_latch = 1'b1;
                    state_next   = S_QMUL2;
                end
            end
            S_QMUL2:
            begin
                cmd.mul_start = 1'b1;
                cmd.sel_a     = OP_A_ACC;
                cmd.sel_b     = OP_B_RD;
                wait_next     = 1'b1;
                state_next    = S_QWAIT;
            end
            S_QWAIT:
            begin
                if (sts.mul_done && !wait_reg)
                begin
                    cmd.acc_load = 1'b1;
                    state_next   = S_IDLE;
                    done_next    = 1'b1;
                    rsp_next.status = ST_OK;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        if (cfg_we)
            ready_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
            wait_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            wait_reg  <= wait_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        n_reg   <= n_next;
        r_reg   <= r_next;
    end

    // the query product lands in acc in the cycle after its done
    logic qsel_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qsel_reg <= 1'b0;
        else
            qsel_reg <= (state_reg == S_QWAIT);
    end

    assign busy      = (state_reg != S_IDLE) || done_reg;
    assign done      = done_reg;
    assign rsp.value = qsel_reg ? acc : rsp_reg.value;
    assign rsp.status = rsp_reg.status;
    assign arg_n     = n_reg;
    assign arg_r     = r_reg;

endmodule

// ===== hw/rtl/binomial_coefficient_mod_prime.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_coefficient_mod_prime
// Binomial coefficients modulo a configurable prime from factorial tables.
// ----------------------------------------------------------------------------
// a query runs two serial modmuls, fact[n] * ifact[r] and then * ifact[n-r];
// errors and r > n answer in the cycle right after accept; a rebuild runs one
// modmul per table entry for the factorials and for the inverse fill, plus up
// to 62 modmuls for the inverse of the top factorial.
// one word at a time while busy is high; the serial multiplier sets the pace.
// reset: tables not built, modulus 1000000007; the receiver cannot stall.
module binomial_coefficient_mod_prime
    import bcmp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  req_t          req,
    output logic          busy,
    output logic          valid,
    output rsp_t          rsp,
    input  logic          cfg_we,
    input  logic [MW-1:0] cfg_data
);

    logic [MW-1:0] modulus_reg;
    cmd_t          cmd;
    sts_t          sts;
    logic [MW-1:0] acc;
    logic [9:0]    arg_n, arg_r;
    logic          start_ok;

    // modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= MOD_RESET;
        else if (cfg_we)
            modulus_reg <= cfg_data;
    end

    assign start_ok = start && !busy;

    bcmp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_ok),
        .req     (req),
        .cfg_we  (cfg_we),
        .modulus (modulus_reg),
        .sts     (sts),
        .acc     (acc),
        .cmd     (cmd),
        .busy    (busy),
        .done    (valid),
        .rsp     (rsp),
        .arg_n   (arg_n),
        .arg_r   (arg_r)
    );

    bcmp_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .modulus (modulus_reg),
        .arg_n   (arg_n),
        .arg_r   (arg_r),
        .sts     (sts),
        .acc     (acc)
    );

endmodule

// ===== hw/rtl/bcmp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcmp_checker
// Port level checks for the binomial coefficient block.
// ----------------------------------------------------------------------------
module bcmp_checker
    import bcmp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic valid,
    input rsp_t rsp
);

    // an accepted word makes the block busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // a result strobe lasts one cycle
    a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid)
        else $error("result strobe longer than one cycle");

    // result only while busy
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy)
        else $error("result while idle");

    // error status carries zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && rsp.status != ST_OK |-> rsp.value == '0)
        else $error("nonzero value with error status");

endmodule

bind binomial_coefficient_mod_prime bcmp_checker u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .valid (valid),
    .rsp   (rsp)
);

// ===== bench/binomial_coefficient_mod_prime_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_coefficient_mod_prime_checker
// Watches the request, response and modulus ports of the block. It keeps its
// own factorial tables and modulus, predicts each response word and compares
// the words in order.
// ----------------------------------------------------------------------------
module binomial_coefficient_mod_prime_checker
    import bcmp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  req_t          req,
    input  logic          valid,
    input  rsp_t          rsp,
    input  logic          cfg_we,
    input  logic [MW-1:0] cfg_data,
    output int            failures,
    output int            outstanding,
    output int            words_checked
);

    logic [MW-1:0] fact_tab [TABLE_SIZE];
    logic [MW-1:0] ifact_tab [TABLE_SIZE];
    logic          built;
    logic [MW-1:0] modulus;
    rsp_t          coeff_q [$];

    // a*b mod modulus; everything is zero for a modulus below two
    function automatic logic [MW-1:0] mod_mul(input longint unsigned a,
                                              input longint unsigned b);
        longint unsigned m;
        m = modulus;
        if (m < 2)
            return '0;
        return MW'(((a % m) * (b % m)) % m);
    endfunction

    // factorials upward, inverse of the top one by exponentiation, then downward
    task automatic build_tables();
        logic [MW-1:0] acc;
        logic [MW-1:0] base;
        logic [31:0]   e;
        fact_tab[0] = mod_mul(1, 1);
        for (int i = 1; i < TABLE_SIZE; i++)
            fact_tab[i] = mod_mul(i, fact_tab[i-1]);
        if (modulus >= 2)
        begin
            acc  = mod_mul(1, 1);
            base = mod_mul(fact_tab[TABLE_SIZE-1], 1);
            e    = modulus - 2;
            while (e != 0)
            begin
                if (e[0])
                    acc = mod_mul(acc, base);
                e    = e >> 1;
                base = mod_mul(base, base);
            end
            ifact_tab[TABLE_SIZE-1] = acc;
        end
        else
            ifact_tab[TABLE_SIZE-1] = '0;
        for (int i = TABLE_SIZE - 1; i > 0; i--)
            ifact_tab[i-1] = mod_mul(i, ifact_tab[i]);
        built = 1'b1;
    endtask

    task automatic predict_coeff(input req_t w, output rsp_t p);
        p = '0;
        if (w.req_type == REQ_REBUILD)
            build_tables();
        else if (!built)
            p.status = ST_NOT_BUILT;
        else if (int'(w.n) >= TABLE_SIZE)
            p.status = ST_RANGE;
        else if (w.r <= w.n)
            p.value = mod_mul(mod_mul(fact_tab[w.n], ifact_tab[w.r]),
                              ifact_tab[w.n - w.r]);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch: got %0d expected %0d", $time, what, got, want);
        failures++;
    endtask

    initial
    begin
        failures      = 0;
        outstanding   = 0;
        words_checked = 0;
    end

    // track config and requests, compare each response word with the oldest
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t p;
        rsp_t e;
        if (!rst_n)
        begin
            built   = 1'b0;
            modulus = MOD_RESET;
            coeff_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                modulus = cfg_data;
                built   = 1'b0;
            end
            if (start && !busy)
            begin
                predict_coeff(req, p);
                coeff_q.push_back(p);
            end
            if (valid)
            begin
                if (coeff_q.size() == 0)
                    report_mismatch("unexpected word, value", rsp.value, 0);
                else
                begin
                    e = coeff_q.pop_front();
                    words_checked++;
                    if (rsp.value !== e.value)
                        report_mismatch("value", rsp.value, e.value);
                    if (rsp.status !== e.status)
                        report_mismatch("status", rsp.status, e.status);
                end
            end
        end
        outstanding = coeff_q.size();
    end

endmodule

// ===== bench/binomial_coefficient_mod_prime_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_coefficient_mod_prime_test
// Drives rebuild and query words through several modulus settings (reset
// value, largest, smallest, non-prime, below two, another prime) with random
// gaps for most words; the checker predicts and compares every response word.
// ----------------------------------------------------------------------------
module binomial_coefficient_mod_prime_test;
    import bcmp_pkg::*;

    logic          clk;
    logic          rst_n;
    logic          start;
    req_t          req;
    logic          busy;
    logic          valid;
    rsp_t          rsp;
    logic          cfg_we;
    logic [MW-1:0] cfg_data;
    int            failures;
    int            outstanding;
    int            words_checked;
    bit            gaps_on;
    int            queries_sent;
    int            settings_run;

    binomial_coefficient_mod_prime uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .busy     (busy),
        .valid    (valid),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    binomial_coefficient_mod_prime_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req           (req),
        .valid         (valid),
        .rsp           (rsp),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .failures      (failures),
        .outstanding   (outstanding),
        .words_checked (words_checked)
    );

    always #5 clk = ~clk;

    // present one word and hold it until the block takes it
    task automatic send_word(input logic kind, input int n, input int r);
        req_t w;
        w.req_type = kind;
        w.n        = n[9:0];
        w.r        = r[9:0];
        start <= 1'b1;
        req   <= w;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        if (kind == REQ_QUERY)
            queries_sent++;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_query(input int n, input int r);
        send_word(REQ_QUERY, n, r);
    endtask

    // random query, mostly with r within n
    task automatic random_query();
        int n;
        int r;
        int pick;
        n    = $urandom_range(0, 1023);
        pick = $urandom_range(0, 9);
        if (pick < 8)
            r = $urandom_range(0, n);
        else if (pick == 8 && n < 1023)
            r = $urandom_range(n + 1, 1023);
        else
            r = $urandom_range(0, 1023);
        send_query(n, r);
    endtask

    // wait until every expected word has come and the block is idle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_modulus(input logic [MW-1:0] m);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    // queries before the rebuild, rebuild, corner queries, random queries
    task automatic run_setting(input int count, input bit last_setting);
        send_query(1023, 0);
        send_query($urandom_range(0, 1023), $urandom_range(0, 1023));
        send_word(REQ_REBUILD, $urandom_range(0, 1023), $urandom_range(0, 1023));
        send_query(0, 0);
        send_query(0, 1);
        send_query(1, 0);
        send_query(1, 1);
        send_query(1023, 0);
        send_query(1023, 1023);
        send_query(1023, 1);
        send_query(1023, 1022);
        send_query(1023, 511);
        send_query(512, 1023);
        send_query(682, 341);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                drain();
            if (last_setting && i == count - count / 3)
                gaps_on = 1'b0;
            random_query();
        end
        settings_run++;
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        gaps_on      = 1'b1;
        queries_sent = 0;
        settings_run = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset modulus, then largest, smallest, non-prime, below two, prime
        run_setting(300, 1'b0);
        write_modulus(31'h7FFFFFFF);
        run_setting(300, 1'b0);
        write_modulus(31'd2);
        run_setting(300, 1'b0);
        write_modulus(31'd12);
        run_setting(280, 1'b0);
        write_modulus(31'd1);
        run_setting(280, 1'b0);
        write_modulus(31'd998244353);
        run_setting(300, 1'b1);

        drain();
        repeat (100) @(posedge clk);
        $display("Covered %0d modulus settings with %0d queries; %0d words checked.",
                 settings_run, queries_sent, words_checked);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // run limit
    initial
    begin
        #50_000_000;
        $display("Timeout with %0d words still expected.", outstanding);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bcmp_pkg.sv
hw/rtl/bcmp_modmul.sv
hw/rtl/bcmp_datapath.sv
hw/rtl/bcmp_ctrl.sv
hw/rtl/binomial_coefficient_mod_prime.sv
hw/rtl/bcmp_checker.sv
bench/binomial_coefficient_mod_prime_checker.sv
bench/binomial_coefficient_mod_prime_test.sv
